>>> rtl/core/shared_exclusive_lock_table_top_defines.svh
// Assertion macros shared by the lock table checker.
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_TOP_DEFINES_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define SLT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lock table check failed");

// Next-cycle implication, disabled while reset is active.
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lock table check failed");

`endif

>>> rtl/core/slt_pkg.sv
// Package with the codes, default sizes and types of the lock table.
package slt_pkg;

  localparam int ENTRIES_DEF     = 1024;
  localparam int THREADS_DEF     = 16;
  localparam int MAX_SHARERS_DEF = 255;

  localparam int CMD_W    = 3;
  localparam int IDX_W    = 10;
  localparam int TID_W    = 4;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SHR_W    = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 3'd0,
    CMD_LOCK_SH = 3'd1,
    CMD_LOCK_EX = 3'd2,
    CMD_UNLOCK  = 3'd3,
    CMD_ADD_THR = 3'd4,
    CMD_REM_THR = 3'd5,
    CMD_INVAL   = 3'd6
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_FREE   = 2'd0,
    MODE_SHARED = 2'd1,
    MODE_EXCL   = 2'd2,
    MODE_OWNED  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_WAIT  = 2'd1,
    ST_ABORT = 2'd2,
    ST_BUSY  = 2'd3
  } status_e;

  typedef enum logic {
    S_CLEAR = 1'b0,
    S_RUN   = 1'b1
  } state_e;

endpackage

>>> rtl/core/slt_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module slt_ram #(
  parameter int DEPTH = slt_pkg::ENTRIES_DEF,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/core/slt_update.sv
// Command logic that computes the new entry contents and the status.
module slt_update #(
  parameter int THREADS     = slt_pkg::THREADS_DEF,
  parameter int MAX_SHARERS = slt_pkg::MAX_SHARERS_DEF,
  parameter int CW          = $clog2(MAX_SHARERS + 1)
) (
  input  slt_pkg::cmd_e           cmd_i,
  input  logic [slt_pkg::TID_W-1:0] tid_i,
  input  slt_pkg::mode_e          init_mode_i,
  input  logic                    cur_valid_i,
  input  slt_pkg::mode_e          cur_mode_i,
  input  logic [CW-1:0]           cur_cnt_i,
  input  logic [THREADS-1:0]      cur_mask_i,
  output logic                    nxt_valid_o,
  output slt_pkg::mode_e          nxt_mode_o,
  output logic [CW-1:0]           nxt_cnt_o,
  output logic [THREADS-1:0]      nxt_mask_o,
  output slt_pkg::status_e        status_o
);

  logic               tid_ok;
  logic [THREADS-1:0] tid_bit;
  logic [CW-1:0]      cnt_dec;

  assign tid_ok  = 32'(tid_i) < THREADS;
  assign tid_bit = THREADS'(1) << tid_i;
  assign cnt_dec = cur_cnt_i - CW'(1);

  always_comb begin
    nxt_valid_o = cur_valid_i;
    nxt_mode_o  = cur_mode_i;
    nxt_cnt_o   = cur_cnt_i;
    nxt_mask_o  = cur_mask_i;
    status_o    = slt_pkg::ST_ABORT;
    if (cmd_i == slt_pkg::CMD_INIT) begin
      nxt_valid_o = 1'b1;
      nxt_mode_o  = init_mode_i;
      nxt_cnt_o   = '0;
      nxt_mask_o  = '0;
      status_o    = slt_pkg::ST_OK;
    end else if (cur_valid_i) begin
      unique case (cmd_i)
        slt_pkg::CMD_LOCK_EX: begin
          if (cur_mode_i == slt_pkg::MODE_OWNED) begin
            status_o = slt_pkg::ST_ABORT;
          end else if (cur_mode_i != slt_pkg::MODE_FREE) begin
            status_o = slt_pkg::ST_WAIT;
          end else if (cur_cnt_i != '0) begin
            status_o = slt_pkg::ST_ABORT;
          end else begin
            nxt_mode_o = slt_pkg::MODE_EXCL;
            nxt_cnt_o  = CW'(1);
            status_o   = slt_pkg::ST_OK;
          end
        end
        slt_pkg::CMD_LOCK_SH: begin
          if (cur_mode_i == slt_pkg::MODE_OWNED) begin
            status_o = slt_pkg::ST_ABORT;
          end else if (cur_mode_i == slt_pkg::MODE_EXCL) begin
            status_o = slt_pkg::ST_WAIT;
          end else if (cur_mode_i == slt_pkg::MODE_FREE) begin
            if (cur_cnt_i != '0) begin
              status_o = slt_pkg::ST_ABORT;
            end else begin
              nxt_mode_o = slt_pkg::MODE_SHARED;
              nxt_cnt_o  = CW'(1);
              status_o   = slt_pkg::ST_OK;
            end
          end else if (cur_cnt_i == '0) begin
            status_o = slt_pkg::ST_ABORT;
          end else if (cur_cnt_i >= CW'(MAX_SHARERS)) begin
            status_o = slt_pkg::ST_WAIT;
          end else begin
            nxt_cnt_o = cur_cnt_i + CW'(1);
            status_o  = slt_pkg::ST_OK;
          end
        end
        slt_pkg::CMD_UNLOCK: begin
          if (cur_mode_i == slt_pkg::MODE_OWNED) begin
            status_o = slt_pkg::ST_ABORT;
          end else if (cur_mode_i == slt_pkg::MODE_EXCL) begin
            if (cur_cnt_i != CW'(1)) begin
              status_o = slt_pkg::ST_ABORT;
            end else begin
              nxt_mode_o = slt_pkg::MODE_FREE;
              nxt_cnt_o  = '0;
              status_o   = slt_pkg::ST_OK;
            end
          end else if (cur_mode_i == slt_pkg::MODE_SHARED) begin
            if (cur_cnt_i == '0) begin
              status_o = slt_pkg::ST_ABORT;
            end else begin
              nxt_cnt_o = cnt_dec;
              if (cnt_dec == '0) begin
                nxt_mode_o = slt_pkg::MODE_FREE;
              end
              status_o = slt_pkg::ST_OK;
            end
          end else begin
            status_o = slt_pkg::ST_OK;
          end
        end
        slt_pkg::CMD_ADD_THR: begin
          if (tid_ok) begin
            nxt_mask_o = cur_mask_i | tid_bit;
            status_o   = slt_pkg::ST_OK;
          end
        end
        slt_pkg::CMD_REM_THR: begin
          if (tid_ok && ((cur_mask_i & tid_bit) != '0)) begin
            nxt_mask_o = cur_mask_i & ~tid_bit;
            status_o   = slt_pkg::ST_OK;
          end
        end
        slt_pkg::CMD_INVAL: begin
          if (cur_mask_i != '0) begin
            status_o = slt_pkg::ST_BUSY;
          end else if (cur_cnt_i != '0) begin
            status_o = slt_pkg::ST_ABORT;
          end else begin
            nxt_mode_o = slt_pkg::MODE_OWNED;
            status_o   = slt_pkg::ST_OK;
          end
        end
        default: begin
          status_o = slt_pkg::ST_ABORT;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/shared_exclusive_lock_table_top.sv
// Top level of the shared/exclusive lock table.
//
// A command is taken at a rising edge with start high and busy low; its result
// passes the request and result registers and appears on the result ports
// for exactly one cycle, marked by result_valid_o; the receiver cannot stall,
// so it must capture the result in that cycle. While busy is low, a new command
// may be issued in every cycle, giving one command per clock. Each command is
// one read-modify-write of its entry: the entry is read from the table RAM in
// the cycle after the request, updated and written back at the end of that
// cycle, and a write-forwarding register supplies the freshest contents when
// the next command hits the same entry. After reset the block holds busy high
// while a clearing pass zeroes the table one entry per cycle; no command is
// taken until then. An index at or above ENTRIES aborts with zero mode and count.
module shared_exclusive_lock_table_top #(
  parameter int ENTRIES     = slt_pkg::ENTRIES_DEF,
  parameter int THREADS     = slt_pkg::THREADS_DEF,
  parameter int MAX_SHARERS = slt_pkg::MAX_SHARERS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [slt_pkg::CMD_W-1:0]    cmd_i,
  input  logic [slt_pkg::IDX_W-1:0]    entry_index_i,
  input  logic [slt_pkg::TID_W-1:0]    thread_id_i,
  input  logic [slt_pkg::MODE_W-1:0]   init_mode_i,
  output logic                         result_valid_o,
  output logic [slt_pkg::STATUS_W-1:0] status_o,
  output logic [slt_pkg::MODE_W-1:0]   entry_mode_after_o,
  output logic [slt_pkg::SHR_W-1:0]    sharers_after_o
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(MAX_SHARERS + 1);
  localparam int EW = 1 + slt_pkg::MODE_W + CW + THREADS;
  localparam int XW = slt_pkg::IDX_W + AW;

  // Clearing sequencer.
  slt_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic            clr_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= slt_pkg::S_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    clr_we    = 1'b0;
    unique case (state_q)
      slt_pkg::S_CLEAR: begin
        clr_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(ENTRIES - 1)) begin
          state_d = slt_pkg::S_RUN;
        end
      end
      slt_pkg::S_RUN: begin
        state_d = slt_pkg::S_RUN;
      end
      default: begin
        state_d = slt_pkg::S_CLEAR;
      end
    endcase
  end

  assign busy = (state_q == slt_pkg::S_CLEAR);

  // Request capture and RAM read.
  logic          accept;
  logic [XW-1:0] idx_ext;
  logic [AW-1:0] rd_addr;
  logic          in_range;

  assign accept   = start && !busy;
  assign idx_ext  = {{AW{1'b0}}, entry_index_i};
  assign rd_addr  = idx_ext[AW-1:0];
  assign in_range = 32'(entry_index_i) < ENTRIES;

  logic                         p_vld_q;
  logic                         p_inrange_q;
  logic [AW-1:0]                p_addr_q;
  logic [slt_pkg::CMD_W-1:0]    p_cmd_q;
  logic [slt_pkg::TID_W-1:0]    p_tid_q;
  logic [slt_pkg::MODE_W-1:0]   p_imode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_inrange_q <= in_range;
      p_addr_q    <= rd_addr;
      p_cmd_q     <= cmd_i;
      p_tid_q     <= thread_id_i;
      p_imode_q   <= init_mode_i;
    end
  end

  // Table RAM; the clearing pass owns the write port while busy.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [EW-1:0] upd_word;
  logic          upd_we;

  assign upd_we    = p_vld_q && p_inrange_q;
  assign ram_we    = clr_we || upd_we;
  assign ram_waddr = clr_we ? clr_cnt_q : p_addr_q;
  assign ram_wdata = clr_we ? '0 : upd_word;

  slt_ram #(
    .DEPTH(ENTRIES),
    .WIDTH(EW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // The RAM returns old data when the previous command wrote the same entry
  // in the cycle of this read, so the last written word is kept and used.
  logic          fwd_vld_q;
  logic [AW-1:0] fwd_addr_q;
  logic [EW-1:0] fwd_data_q;
  logic [EW-1:0] cur_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= upd_we && !clr_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      fwd_addr_q <= p_addr_q;
      fwd_data_q <= upd_word;
    end
  end

  assign cur_word = (fwd_vld_q && (fwd_addr_q == p_addr_q)) ? fwd_data_q : ram_rdata;

  // Entry update.
  logic               nxt_valid;
  slt_pkg::mode_e     nxt_mode;
  logic [CW-1:0]      nxt_cnt;
  logic [THREADS-1:0] nxt_mask;
  slt_pkg::status_e   upd_status;

  slt_update #(
    .THREADS    (THREADS),
    .MAX_SHARERS(MAX_SHARERS),
    .CW         (CW)
  ) u_update (
    .cmd_i      (slt_pkg::cmd_e'(p_cmd_q)),
    .tid_i      (p_tid_q),
    .init_mode_i(slt_pkg::mode_e'(p_imode_q)),
    .cur_valid_i(cur_word[EW-1]),
    .cur_mode_i (slt_pkg::mode_e'(cur_word[EW-2 -: slt_pkg::MODE_W])),
    .cur_cnt_i  (cur_word[THREADS +: CW]),
    .cur_mask_i (cur_word[THREADS-1:0]),
    .nxt_valid_o(nxt_valid),
    .nxt_mode_o (nxt_mode),
    .nxt_cnt_o  (nxt_cnt),
    .nxt_mask_o (nxt_mask),
    .status_o   (upd_status)
  );

  assign upd_word = {nxt_valid, nxt_mode, nxt_cnt, nxt_mask};

  // Result register.
  logic [CW+slt_pkg::SHR_W-1:0] cnt_ext;
  logic                         res_vld_q;
  logic [slt_pkg::STATUS_W-1:0] res_status_q;
  logic [slt_pkg::MODE_W-1:0]   res_mode_q;
  logic [slt_pkg::SHR_W-1:0]    res_shr_q;

  assign cnt_ext = {{slt_pkg::SHR_W{1'b0}}, nxt_cnt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      if (p_inrange_q) begin
        res_status_q <= upd_status;
        res_mode_q   <= nxt_mode;
        res_shr_q    <= cnt_ext[slt_pkg::SHR_W-1:0];
      end else begin
        res_status_q <= slt_pkg::ST_ABORT;
        res_mode_q   <= '0;
        res_shr_q    <= '0;
      end
    end
  end

  assign result_valid_o     = res_vld_q;
  assign status_o           = res_status_q;
  assign entry_mode_after_o = res_mode_q;
  assign sharers_after_o    = res_shr_q;

endmodule

>>> rtl/core/slt_checker.sv
// Port-level checker for the lock table and its bind to the top level.
`include "shared_exclusive_lock_table_top_defines.svh"

module slt_checker #(
  parameter int ENTRIES = slt_pkg::ENTRIES_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [slt_pkg::CMD_W-1:0]    cmd_i,
  input logic [slt_pkg::IDX_W-1:0]    entry_index_i,
  input logic                         result_valid_o,
  input logic [slt_pkg::STATUS_W-1:0] status_o,
  input logic [slt_pkg::MODE_W-1:0]   entry_mode_after_o,
  input logic [slt_pkg::SHR_W-1:0]    sharers_after_o
);

  // Every result stems from a request taken with start high and busy low.
  `SLT_ASSERT_IMPLY(a_result_has_request, clk_i, rst_ni, result_valid_o, $past(start && !busy, 2))

  // An index beyond the table aborts with mode and count of zero.
  `SLT_ASSERT_IMPLY(a_range_abort, clk_i, rst_ni, result_valid_o && (32'($past(entry_index_i, 2)) >= ENTRIES), status_o == slt_pkg::ST_ABORT && entry_mode_after_o == '0 && sharers_after_o == '0)

  // A granted exclusive lock leaves the entry exclusive with one holder.
  `SLT_ASSERT_IMPLY(a_excl_grant, clk_i, rst_ni, result_valid_o && $past(cmd_i, 2) == slt_pkg::CMD_LOCK_EX && status_o == slt_pkg::ST_OK, entry_mode_after_o == slt_pkg::MODE_EXCL && sharers_after_o == 8'd1)

  // No result leaves the block while the table is still being cleared.
  `SLT_ASSERT_NEXT(a_no_result_in_clear, clk_i, rst_ni, busy, !result_valid_o)

endmodule

bind shared_exclusive_lock_table_top slt_checker #(
  .ENTRIES(ENTRIES)
) u_slt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .cmd_i             (cmd_i),
  .entry_index_i     (entry_index_i),
  .result_valid_o    (result_valid_o),
  .status_o          (status_o),
  .entry_mode_after_o(entry_mode_after_o),
  .sharers_after_o   (sharers_after_o)
);
